>>> src/lwd_pkg.sv
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared types, sizes and helpers for the LMS weight delta block.
// ----------------------------------------------------------------------------
package lwd_pkg;

   localparam int MAX_LINKS = 32;
   localparam int IDX_W     = $clog2(MAX_LINKS);
   localparam int WORD_W    = 32;
   localparam int DWORD_W   = 64;
   localparam int FRAC_W    = 16;
   localparam int LINK_W    = 5;
   localparam int CSR_IDX_W = 2;

   typedef logic signed [WORD_W-1:0]  word_type;
   typedef logic signed [DWORD_W-1:0] dword_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [LINK_W-1:0]         link_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;

   localparam csr_idx_type REG_WEIGHT_RATE   = 2'd0;
   localparam csr_idx_type REG_BIAS_RATE     = 2'd1;
   localparam csr_idx_type REG_TIME_SCALE    = 2'd2;
   localparam csr_idx_type REG_FEEDBACK_GAIN = 2'd3;

   localparam word_type WORD_MAX       = 32'sh7fff_ffff;
   localparam word_type WORD_MIN       = 32'sh8000_0000;
   localparam word_type TIME_SCALE_RST = 32'sh0001_0000;

   // saturate a wide signed value to one word
   function automatic word_type sat_word(input dword_type v);
      word_type r;
      if (v > DWORD_W'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (v < DWORD_W'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/lwd_if.sv
// ----------------------------------------------------------------------------
// lwd_if
// Valid/ready channels of the LMS weight delta block.
// ----------------------------------------------------------------------------
interface lwd_req_if;
   logic              valid;
   logic              ready;
   lwd_pkg::word_type weight;
   lwd_pkg::word_type afferent;
   logic              present;
   lwd_pkg::word_type target;
   logic              is_last;

   modport source (output valid, weight, afferent, present, target, is_last, input ready);
   modport sink   (input valid, weight, afferent, present, target, is_last, output ready);
endinterface

interface lwd_rsp_if;
   logic              valid;
   logic              ready;
   lwd_pkg::link_type link_index;
   lwd_pkg::word_type weight_delta;
   logic              clear_weight;
   lwd_pkg::word_type feedback;
   logic              last_result;

   modport source (output valid, link_index, weight_delta, clear_weight, feedback,
                   last_result, input ready);
   modport sink   (input valid, link_index, weight_delta, clear_weight, feedback,
                   last_result, output ready);
endinterface

interface lwd_csr_if;
   logic                 valid;
   logic                 ready;
   lwd_pkg::csr_idx_type index;
   lwd_pkg::word_type    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/lwd_ram.sv
// ----------------------------------------------------------------------------
// lwd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lwd_qmul.sv
// ----------------------------------------------------------------------------
// lwd_qmul
// Shared Q16.16 multiplier: registered product, floor shift and saturation.
// ----------------------------------------------------------------------------
module lwd_qmul (
   input  logic              clock,
   input  lwd_pkg::word_type op_a,
   input  lwd_pkg::word_type op_b,
   output lwd_pkg::word_type q
);
   import lwd_pkg::*;

   dword_type prod_in;
   dword_type prod_ff;
   dword_type shifted;

   assign prod_in = DWORD_W'(op_a) * DWORD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic shift rounds toward minus infinity
   assign shifted = prod_ff >>> FRAC_W;
   assign q       = sat_word(shifted);

endmodule

>>> src/lms_weight_delta.sv
// ----------------------------------------------------------------------------
// lms_weight_delta
// Delta-rule learning step over a run of weight/input pairs, bias entry last.
// ----------------------------------------------------------------------------
// load: each request is taken in S_LOAD and multiplied, then S_ACC accumulates it into the sum; the next waits
// end of run: S_ERR forms the error, then S_M0 to S_M5 form the feedback and the scaled rates
// results: per link delta S_RD reads the ram, S_MUL and S_OUT use the shared multiplier, then the bias
// all multiplies go through one 32x32 multiplier with a registered product
// reset clears the sequencer, the sum, the link count and the rate and gain registers; time scale resets to one
module lms_weight_delta (
   input  logic clock,
   input  logic reset,
   lwd_req_if.sink   req_ch,
   lwd_rsp_if.source rsp_ch,
   lwd_csr_if.sink   csr_ch
);
   import lwd_pkg::*;

   localparam logic [3:0] S_LOAD = 4'd0;
   localparam logic [3:0] S_ACC  = 4'd1;
   localparam logic [3:0] S_ERR  = 4'd2;
   localparam logic [3:0] S_M0   = 4'd3;
   localparam logic [3:0] S_M1   = 4'd4;
   localparam logic [3:0] S_M2   = 4'd5;
   localparam logic [3:0] S_M3   = 4'd6;
   localparam logic [3:0] S_M4   = 4'd7;
   localparam logic [3:0] S_M5   = 4'd8;
   localparam logic [3:0] S_RD   = 4'd9;
   localparam logic [3:0] S_MUL  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;
   localparam logic [3:0] S_BIAS = 4'd12;

   localparam idx_type LAST_POS = IDX_W'(MAX_LINKS - 1);

   logic [3:0] state_ff, state_in;
   idx_type    cnt_ff, cnt_in;
   idx_type    j_ff, j_in;
   dword_type  sum_ff, sum_in;
   logic       last_ff, last_in;
   logic       pres_ff, pres_in;
   word_type   target_ff, target_in;
   word_type   err_ff, err_in;
   word_type   fb_ff, fb_in;
   word_type   chunk_ff, chunk_in;
   word_type   bias_ff, bias_in;

   word_type   wrate_ff, wrate_in;
   word_type   brate_ff, brate_in;
   word_type   tscale_ff, tscale_in;
   word_type   gain_ff, gain_in;

   logic       rsp_valid_ff, rsp_valid_in;
   link_type   rsp_idx_ff, rsp_idx_in;
   word_type   rsp_delta_ff, rsp_delta_in;
   logic       rsp_clr_ff, rsp_clr_in;
   word_type   rsp_fb_ff, rsp_fb_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       req_accept;
   logic       out_free;
   word_type   nerr;
   word_type   mul_a, mul_b;
   word_type   qres;
   logic [WORD_W:0] ram_rdata;
   logic       lnk_pres;
   word_type   lnk_aff;

   assign req_ch.ready = (state_ff == S_LOAD);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign nerr         = (err_ff == WORD_MIN) ? WORD_MAX : -err_ff;
   assign lnk_pres     = ram_rdata[WORD_W];
   assign lnk_aff      = ram_rdata[WORD_W-1:0];

   lwd_ram #(
      .WIDTH (WORD_W + 1),
      .DEPTH (MAX_LINKS)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (cnt_ff),
      .wr_data ({req_ch.present, req_ch.afferent}),
      .rd_addr (j_ff),
      .rd_data (ram_rdata)
   );

   lwd_qmul u_qmul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .q     (qres)
   );

   // operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         S_M0: begin
            mul_a = gain_ff;
            mul_b = nerr;
         end
         S_M1: begin
            mul_a = wrate_ff;
            mul_b = err_ff;
         end
         S_M2, S_M4: begin
            mul_a = qres;
            mul_b = tscale_ff;
         end
         S_M3: begin
            mul_a = brate_ff;
            mul_b = err_ff;
         end
         S_MUL, S_OUT: begin
            mul_a = chunk_ff;
            mul_b = lnk_aff;
         end
         default: begin
            mul_a = req_ch.weight;
            mul_b = req_ch.afferent;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      j_in         = j_ff;
      sum_in       = sum_ff;
      last_in      = last_ff;
      pres_in      = pres_ff;
      target_in    = target_ff;
      err_in       = err_ff;
      fb_in        = fb_ff;
      chunk_in     = chunk_ff;
      bias_in      = bias_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_delta_in = rsp_delta_ff;
      rsp_clr_in   = rsp_clr_ff;
      rsp_fb_in    = rsp_fb_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               pres_in   = req_ch.present;
               target_in = req_ch.target;
               last_in   = req_ch.is_last || (cnt_ff == LAST_POS);
               state_in  = S_ACC;
            end
         end
         S_ACC: begin
            if (pres_ff) begin
               sum_in = sum_ff + DWORD_W'(qres);
            end
            if (last_ff) begin
               state_in = S_ERR;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_ERR: begin
            err_in   = sat_word(DWORD_W'(target_ff) - sum_ff);
            state_in = S_M0;
         end
         S_M0: state_in = S_M1;
         S_M1: begin
            fb_in    = qres;
            state_in = S_M2;
         end
         S_M2: state_in = S_M3;
         S_M3: begin
            chunk_in = qres;
            state_in = S_M4;
         end
         S_M4: state_in = S_M5;
         S_M5: begin
            bias_in  = qres;
            j_in     = '0;
            state_in = (cnt_ff == '0) ? S_BIAS : S_RD;
         end
         S_RD:  state_in = S_MUL;
         S_MUL: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = LINK_W'(j_ff);
               rsp_delta_in = lnk_pres ? qres : '0;
               rsp_clr_in   = !lnk_pres;
               rsp_fb_in    = fb_ff;
               rsp_last_in  = 1'b0;
               j_in         = j_ff + 1'b1;
               state_in     = (j_ff + 1'b1 == cnt_ff) ? S_BIAS : S_RD;
            end
         end
         S_BIAS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = LINK_W'(cnt_ff);
               rsp_delta_in = bias_ff;
               rsp_clr_in   = 1'b0;
               rsp_fb_in    = fb_ff;
               rsp_last_in  = 1'b1;
               sum_in       = '0;
               cnt_in       = '0;
               state_in     = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_comb begin
      wrate_in  = wrate_ff;
      brate_in  = brate_ff;
      tscale_in = tscale_ff;
      gain_in   = gain_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            REG_WEIGHT_RATE:   wrate_in  = csr_ch.data;
            REG_BIAS_RATE:     brate_in  = csr_ch.data;
            REG_TIME_SCALE:    tscale_in = csr_ch.data;
            REG_FEEDBACK_GAIN: gain_in   = csr_ch.data;
            default:           wrate_in  = wrate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         j_ff         <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wrate_ff     <= '0;
         brate_ff     <= '0;
         tscale_ff    <= TIME_SCALE_RST;
         gain_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         j_ff         <= j_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         wrate_ff     <= wrate_in;
         brate_ff     <= brate_in;
         tscale_ff    <= tscale_in;
         gain_ff      <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      pres_ff      <= pres_in;
      target_ff    <= target_in;
      err_ff       <= err_in;
      fb_ff        <= fb_in;
      chunk_ff     <= chunk_in;
      bias_ff      <= bias_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_clr_ff   <= rsp_clr_in;
      rsp_fb_ff    <= rsp_fb_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.link_index   = rsp_idx_ff;
   assign rsp_ch.weight_delta = rsp_delta_ff;
   assign rsp_ch.clear_weight = rsp_clr_ff;
   assign rsp_ch.feedback     = rsp_fb_ff;
   assign rsp_ch.last_result  = rsp_last_ff;

endmodule

>>> tb/lwd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_checker
// Watches the request, response and register channels of the LMS weight
// delta block, predicts the deltas of every run from its own copy of the
// registers and link store, and compares each response in order.
// ----------------------------------------------------------------------------
module lwd_checker (
   input  logic clock,
   input  logic reset,
   lwd_req_if   req_ch,
   lwd_rsp_if   rsp_ch,
   lwd_csr_if   csr_ch,
   output int   fail_count,
   output int   deltas_pending
);
   import lwd_pkg::*;

   typedef struct {
      link_type link_index;
      word_type weight_delta;
      logic     clear_weight;
      word_type feedback;
      logic     last_result;
   } delta_rec_type;

   word_type      weight_rate;
   word_type      bias_rate;
   word_type      time_scale;
   word_type      feedback_gain;
   word_type      afferent_mem [MAX_LINKS];
   logic          present_mem [MAX_LINKS];
   dword_type     pred_sum;
   int            link_count;
   delta_rec_type delta_q [$];

   initial begin
      fail_count     = 0;
      deltas_pending = 0;
   end

   function automatic word_type clamp_word(input dword_type v);
      if (v > dword_type'(WORD_MAX)) begin
         return WORD_MAX;
      end
      if (v < dword_type'(WORD_MIN)) begin
         return WORD_MIN;
      end
      return v[WORD_W-1:0];
   endfunction

   // full product, floor shift back to q16.16, then clamp
   function automatic word_type fx_mul(input word_type a, input word_type b);
      dword_type prod;
      prod = dword_type'(a) * dword_type'(b);
      return clamp_word(prod >>> FRAC_W);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ERROR %s: got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic predict_deltas(input word_type w, input word_type a, input logic pres,
                                 input word_type tgt, input logic last);
      int            pos;
      int            n;
      int            j;
      word_type      err;
      word_type      fb;
      word_type      chunk;
      word_type      bias_d;
      delta_rec_type r;
      pos = link_count;
      if (pos >= MAX_LINKS) begin
         pos = MAX_LINKS - 1;
      end
      afferent_mem[pos] = a;
      present_mem[pos]  = pres;
      if (pres) begin
         pred_sum = pred_sum + dword_type'(fx_mul(w, a));
      end
      if (!last && pos < MAX_LINKS - 1) begin
         link_count = pos + 1;
         return;
      end
      n      = pos + 1;
      err    = clamp_word(dword_type'(tgt) - pred_sum);
      fb     = fx_mul(feedback_gain, clamp_word(-dword_type'(err)));
      chunk  = fx_mul(fx_mul(weight_rate, err), time_scale);
      bias_d = fx_mul(fx_mul(bias_rate, err), time_scale);
      for (j = 0; j < n; j++) begin
         r.link_index   = link_type'(j);
         r.feedback     = fb;
         r.clear_weight = 1'b0;
         r.last_result  = 1'b0;
         if (j == n - 1) begin
            r.weight_delta = bias_d;
            r.last_result  = 1'b1;
         end else if (present_mem[j]) begin
            r.weight_delta = fx_mul(chunk, afferent_mem[j]);
         end else begin
            r.weight_delta = '0;
            r.clear_weight = 1'b1;
         end
         delta_q.push_back(r);
      end
      pred_sum   = '0;
      link_count = 0;
   endtask

   always @(posedge clock) begin : monitor
      delta_rec_type want;
      if (reset) begin
         weight_rate   = '0;
         bias_rate     = '0;
         time_scale    = TIME_SCALE_RST;
         feedback_gain = '0;
         pred_sum      = '0;
         link_count    = 0;
         delta_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_WEIGHT_RATE:   weight_rate   = csr_ch.data;
               REG_BIAS_RATE:     bias_rate     = csr_ch.data;
               REG_TIME_SCALE:    time_scale    = csr_ch.data;
               REG_FEEDBACK_GAIN: feedback_gain = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_deltas(req_ch.weight, req_ch.afferent, req_ch.present,
                           req_ch.target, req_ch.is_last);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (delta_q.size() == 0) begin
               report_mismatch("response with no delta outstanding",
                               32'(rsp_ch.link_index), '0);
            end else begin
               want = delta_q.pop_front();
               if (rsp_ch.link_index !== want.link_index) begin
                  report_mismatch("link_index", 32'(rsp_ch.link_index),
                                  32'(want.link_index));
               end
               if (rsp_ch.weight_delta !== want.weight_delta) begin
                  report_mismatch("weight_delta", rsp_ch.weight_delta, want.weight_delta);
               end
               if (rsp_ch.clear_weight !== want.clear_weight) begin
                  report_mismatch("clear_weight", 32'(rsp_ch.clear_weight),
                                  32'(want.clear_weight));
               end
               if (rsp_ch.feedback !== want.feedback) begin
                  report_mismatch("feedback", rsp_ch.feedback, want.feedback);
               end
               if (rsp_ch.last_result !== want.last_result) begin
                  report_mismatch("last_result", 32'(rsp_ch.last_result),
                                  32'(want.last_result));
               end
            end
         end
      end
      deltas_pending <= delta_q.size();
   end

endmodule

>>> tb/tb_lms_weight_delta.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lms_weight_delta
// Drives runs of weight/input requests and register writes into the LMS
// weight delta block with random pacing on both channels; a checker beside
// the block predicts and compares every delta.
// ----------------------------------------------------------------------------
module tb_lms_weight_delta;
   import lwd_pkg::*;

   localparam word_type ONE     = 32'sh0001_0000;
   localparam word_type HALF    = 32'sh0000_8000;
   localparam word_type QUARTER = 32'sh0000_4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   pace_on = 1'b1;
   int   fail_count;
   int   deltas_pending;
   int   items_sent = 0;
   int   ready_hold = 0;

   lwd_req_if req_ch ();
   lwd_rsp_if rsp_ch ();
   lwd_csr_if csr_ch ();

   lms_weight_delta u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   lwd_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .fail_count     (fail_count),
      .deltas_pending (deltas_pending)
   );

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic word_type pick_word();
      int       roll;
      word_type v;
      roll = $urandom_range(0, 99);
      v    = $urandom;
      if (roll < 4) begin
         return WORD_MAX;
      end
      if (roll < 8) begin
         return WORD_MIN;
      end
      if (roll < 10) begin
         return '0;
      end
      if (roll < 35) begin
         return v;
      end
      return v >>> $urandom_range(9, 23);
   endfunction

   function automatic word_type pick_rate();
      int       roll;
      word_type v;
      roll = $urandom_range(0, 99);
      v    = $urandom;
      if (roll < 5) begin
         return WORD_MAX;
      end
      if (roll < 10) begin
         return WORD_MIN;
      end
      if (roll < 13) begin
         return '0;
      end
      if (roll < 20) begin
         return v;
      end
      return v >>> $urandom_range(13, 20);
   endfunction

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         ready_hold--;
         rsp_ch.ready <= 1'b0;
      end else begin
         ready_hold = pace_on ? idle_length() : 0;
         rsp_ch.ready <= (ready_hold == 0);
         if (ready_hold > 0) begin
            ready_hold--;
         end
      end
   end

   task automatic send_link(input word_type w, input word_type a, input logic pres,
                            input word_type tgt, input logic last);
      int gap;
      req_ch.valid    <= 1'b1;
      req_ch.weight   <= w;
      req_ch.afferent <= a;
      req_ch.present  <= pres;
      req_ch.target   <= tgt;
      req_ch.is_last  <= last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      gap = pace_on ? idle_length() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_run(input int len, input bit no_end_flag);
      int i;
      for (i = 0; i < len; i++) begin
         send_link(pick_word(), pick_word(), ($urandom_range(0, 4) != 0), pick_word(),
                   (i == len - 1) && !no_end_flag);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (deltas_pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input word_type val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_rates(input word_type wr, input word_type br, input word_type ts,
                            input word_type fg);
      write_reg(REG_WEIGHT_RATE, wr);
      write_reg(REG_BIAS_RATE, br);
      write_reg(REG_TIME_SCALE, ts);
      write_reg(REG_FEEDBACK_GAIN, fg);
   endtask

   initial begin
      int i;
      int phase_no;
      int phase_items;
      int roll;
      int len;
      bit cut;
      req_ch.valid    = 1'b0;
      req_ch.weight   = '0;
      req_ch.afferent = '0;
      req_ch.present  = 1'b0;
      req_ch.target   = '0;
      req_ch.is_last  = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = REG_WEIGHT_RATE;
      csr_ch.data     = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the rates, bias-only run
      send_link(ONE, 32'sh0002_0000, 1'b1, 32'sh0003_0000, 1'b1);
      wait_drained();
      set_rates(HALF, QUARTER, ONE, ONE);
      send_link(ONE, 32'sh0003_0000, 1'b1, '0, 1'b0);
      send_link(32'sh0002_0000, ONE, 1'b0, '0, 1'b0);
      send_link(-HALF, 32'sh0004_8000, 1'b1, '0, 1'b0);
      send_link(HALF, ONE, 1'b1, 32'sh0005_0000, 1'b1);
      // extreme operands, damaged bias entry
      send_link(WORD_MAX, WORD_MAX, 1'b1, '0, 1'b0);
      send_link(WORD_MIN, WORD_MAX, 1'b1, '0, 1'b0);
      send_link(WORD_MIN, WORD_MIN, 1'b1, '0, 1'b0);
      send_link(WORD_MIN, WORD_MIN, 1'b0, WORD_MIN, 1'b1);
      // error clamps low, negated error clamps high
      for (i = 0; i < 3; i++) begin
         send_link(WORD_MAX, WORD_MAX, 1'b1, WORD_MIN, i == 2);
      end
      // error clamps high
      send_link(WORD_MAX, WORD_MIN, 1'b1, '0, 1'b0);
      send_link(WORD_MAX, WORD_MIN, 1'b1, '0, 1'b0);
      send_link('0, '0, 1'b1, WORD_MAX, 1'b1);
      wait_drained();
      set_rates(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN);
      send_link(ONE, WORD_MAX, 1'b1, ONE, 1'b0);
      send_link(ONE, WORD_MIN, 1'b1, '0, 1'b0);
      send_link(-ONE, 32'sh5555_aaaa, 1'b1, -ONE, 1'b1);
      send_link(ONE, ONE, 1'b0, '0, 1'b1);
      // every link damaged
      send_link(ONE, ONE, 1'b0, '0, 1'b0);
      send_link(ONE, ONE, 1'b0, '0, 1'b0);
      send_link(ONE, ONE, 1'b0, ONE, 1'b1);

      for (phase_no = 0; items_sent < 375; phase_no++) begin
         wait_drained();
         case (phase_no)
            0: set_rates(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
            1: set_rates(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
            2: set_rates('0, '0, '0, '0);
            default: set_rates(pick_rate(), pick_rate(), pick_rate(), pick_rate());
         endcase
         pace_on <= ($urandom_range(0, 3) != 0);
         if (phase_no == 0) begin
            send_run(MAX_LINKS, 1'b1);
         end
         phase_items = 0;
         while (phase_items < 60) begin
            roll = $urandom_range(0, 99);
            cut  = 1'b0;
            if (roll < 70) begin
               len = $urandom_range(1, 6);
            end else if (roll < 90) begin
               len = $urandom_range(7, 16);
            end else if (roll < 97) begin
               len = $urandom_range(17, MAX_LINKS);
            end else begin
               len = MAX_LINKS;
               cut = 1'b1;
            end
            send_run(len, cut);
            phase_items += len;
            if ($urandom_range(0, 9) == 0) begin
               wait_drained();
            end
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
